### sv/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// opcodes, status codes and controller/datapath handoff types
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam logic [7:0] OP_PUSH = 8'd0;
  localparam logic [7:0] OP_ADD  = 8'd1;
  localparam logic [7:0] OP_SUB  = 8'd2;
  localparam logic [7:0] OP_MUL  = 8'd3;
  localparam logic [7:0] OP_DIV  = 8'd4;
  localparam logic [7:0] OP_EQ   = 8'd5;
  localparam logic [7:0] OP_NE   = 8'd6;
  localparam logic [7:0] OP_GT   = 8'd7;
  localparam logic [7:0] OP_GE   = 8'd8;
  localparam logic [7:0] OP_LT   = 8'd9;
  localparam logic [7:0] OP_LE   = 8'd10;
  localparam logic [7:0] OP_JMP  = 8'd11;
  localparam logic [7:0] OP_JEZ  = 8'd12;
  localparam logic [7:0] OP_CALL = 8'd13;
  localparam logic [7:0] OP_RET  = 8'd14;
  localparam logic [7:0] OP_PSHV = 8'd15;
  localparam logic [7:0] OP_LDV  = 8'd16;
  localparam logic [7:0] OP_STV  = 8'd17;
  localparam logic [7:0] OP_HALT = 8'd18;

  localparam logic [3:0] ST_RUN     = 4'd0;
  localparam logic [3:0] ST_HALT    = 4'd1;
  localparam logic [3:0] ST_UNKNOWN = 4'd2;
  localparam logic [3:0] ST_OVER    = 4'd3;
  localparam logic [3:0] ST_UNDER   = 4'd4;
  localparam logic [3:0] ST_RANGE   = 4'd5;
  localparam logic [3:0] ST_NOFRAME = 4'd6;
  localparam logic [3:0] ST_DIVZERO = 4'd7;
  localparam logic [3:0] ST_TARGET  = 4'd8;

  localparam logic REQ_START = 1'b0;

  typedef enum logic [1:0] {
    K_PLAIN,
    K_ARITH,
    K_CALL
  } kind_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic arith_wb;
    logic call2;
    logic clr;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  arith_done;
    logic  clr_last;
    logic  out_valid;
  } stat_t;

endpackage

### sv/sme_if.sv
// ----------------------------------------------------------------------------
// sme_if
// valid/ready channels for instruction beats and result beats
// ----------------------------------------------------------------------------
interface sme_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  opcode;
  logic [63:0] argument;
  logic [15:0] instr_addr;
  modport source(output valid, req_type, opcode, argument, instr_addr, input ready);
  modport sink(input valid, req_type, opcode, argument, instr_addr, output ready);
endinterface

interface sme_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] next_pc;
  logic [63:0] top_value;
  logic [8:0]  stack_count;
  modport source(output valid, status, next_pc, top_value, stack_count, input ready);
  modport sink(input valid, status, next_pc, top_value, stack_count, output ready);
endinterface

### sv/sme_muldiv.sv
// ----------------------------------------------------------------------------
// sme_muldiv
// iterative 64-bit wrapping multiply (shared 32x32) and restoring divide
// ----------------------------------------------------------------------------
module sme_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [6:0] MUL_LAST = 7'd3;
  localparam logic [6:0] DIV_LAST = 7'd63;

  logic        busy_r, div_r, done_r;
  logic [6:0]  cnt_r;
  logic [63:0] a_r, b_r, acc_r, prod_r;
  logic [64:0] rem_r;
  logic [31:0] mx, my;
  logic [63:0] prod_nxt, acc_nxt;
  logic [64:0] rs, rem_nxt;
  logic        last;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        mx = a_r[31:0];
        my = b_r[31:0];
      end
      2'd1: begin
        mx = a_r[31:0];
        my = b_r[63:32];
      end
      default: begin
        mx = a_r[63:32];
        my = b_r[31:0];
      end
    endcase
    prod_nxt = mx * my;
    rs = {rem_r[63:0], acc_r[63]};
    rem_nxt = rs;
    acc_nxt = acc_r;
    if (div_r) begin
      if (rs >= {1'b0, b_r}) begin
        rem_nxt = rs - {1'b0, b_r};
        acc_nxt = {acc_r[62:0], 1'b1};
      end else begin
        acc_nxt = {acc_r[62:0], 1'b0};
      end
    end else begin
      case (cnt_r[1:0])
        2'd0: acc_nxt = acc_r;
        2'd1: acc_nxt = prod_r;
        default: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
      endcase
    end
    last = div_r ? (cnt_r == DIV_LAST) : (cnt_r == MUL_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      a_r   <= a;
      b_r   <= b;
      acc_r <= is_div ? a : 64'd0;
      rem_r <= '0;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

### sv/sme_ctrl.sv
// ----------------------------------------------------------------------------
// sme_ctrl
// sequencer: store clear, accept, execute, arithmetic wait, second call write
// ----------------------------------------------------------------------------
module sme_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  sme_pkg::stat_t st,
  output sme_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_ARITH = 5'b01000,
    S_CALL2 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && (!st.out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    state_nxt  = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (st.kind)
          sme_pkg::K_ARITH: state_nxt = S_ARITH;
          sme_pkg::K_CALL:  state_nxt = S_CALL2;
          default:          state_nxt = S_IDLE;
        endcase
      end
      S_ARITH: begin
        if (st.arith_done) begin
          cmd.arith_wb = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CALL2: begin
        cmd.call2 = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

### sv/sme_dpath.sv
// ----------------------------------------------------------------------------
// sme_dpath
// stacks, pointers, instruction decode and fault checks, result register
// ----------------------------------------------------------------------------
module sme_dpath #(
  parameter int DATA_DEPTH = 256,
  parameter int CALL_DEPTH = 256,
  parameter int ADDR_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sme_pkg::cmd_t  cmd,
  output sme_pkg::stat_t st,
  input  logic           in_req_type,
  input  logic [7:0]     in_opcode,
  input  logic [63:0]    in_argument,
  input  logic [15:0]    in_instr_addr,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [3:0]     out_status,
  output logic [15:0]    out_next_pc,
  output logic [63:0]    out_top_value,
  output logic [8:0]     out_stack_count
);

  localparam int DI_W = $clog2(DATA_DEPTH);
  localparam int DP_W = $clog2(DATA_DEPTH + 1);
  localparam int CI_W = $clog2(CALL_DEPTH);
  localparam int CP_W = $clog2(CALL_DEPTH + 1);
  localparam logic [32:0] AM33  = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] AMASK = AM33[31:0];
  localparam logic [63:0] TMASK = {32'hFFFF_FFFF, ~AMASK};
  localparam logic [31:0] DD    = 32'(DATA_DEPTH);
  localparam logic [31:0] CD    = 32'(CALL_DEPTH);
  localparam logic [CI_W-1:0] CLR_END = CI_W'(CALL_DEPTH - 1);

  logic [63:0] ds_mem [DATA_DEPTH];
  logic [63:0] cs_mem [CALL_DEPTH];

  logic [DP_W-1:0] dp_r, dp_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt, fp_r, fp_nxt, fd_r, fd_nxt;
  logic [3:0]      stop_r, stop_nxt;
  logic [63:0]     top_r, top_nxt;
  logic            typ_r;
  logic [7:0]      op_r;
  logic [63:0]     arg_r;
  logic [31:0]     pc_r;
  logic [63:0]     ds_rd_r, cs_rd_a_r, cs_rd_b_r;
  logic [CI_W-1:0] clr_r;
  logic            out_valid_r;
  logic [3:0]      o_st_r;
  logic [15:0]     o_pc_r;

  logic [CP_W-1:0] ra_a, ra_b, loc_a;
  logic [DP_W-1:0] dp_m1, dp_m2;
  logic [31:0]     pc1, pc9, npc;
  logic [63:0]     a, b, r;
  logic            fault;
  logic [3:0]      fcode, st_out;
  sme_pkg::kind_t  kind;
  logic            ds_we, cs_we, arith_ok, tgt_bad, loc_bad;
  logic [DI_W-1:0] ds_wa;
  logic [CI_W-1:0] cs_wa;
  logic [63:0]     ds_wd, cs_wd;
  logic            ds_we_x, cs_we_x, load_out;
  logic [DI_W-1:0] ds_wa_x;
  logic [CI_W-1:0] cs_wa_x;
  logic [63:0]     ds_wd_x, cs_wd_x;
  logic            md_done;
  logic [63:0]     md_res;
  logic [31:0]     dp32;

  assign ra_a  = fp_r + ((in_opcode == sme_pkg::OP_LDV) ? in_argument[CP_W-1:0] : '0);
  assign ra_b  = fp_r + CP_W'(1);
  assign loc_a = fp_r + arg_r[CP_W-1:0];
  assign dp_m1 = dp_r - DP_W'(1);
  assign dp_m2 = dp_r - DP_W'(2);
  assign pc1   = (pc_r + 32'd1) & AMASK;
  assign pc9   = (pc_r + 32'd9) & AMASK;
  assign a     = ds_rd_r;
  assign b     = top_r;
  assign tgt_bad = |(arg_r & TMASK);
  assign loc_bad = arg_r >= 64'(cp_r - fp_r);

  always_comb begin
    case (op_r)
      sme_pkg::OP_ADD: r = a + b;
      sme_pkg::OP_SUB: r = a - b;
      sme_pkg::OP_EQ:  r = {63'd0, a == b};
      sme_pkg::OP_NE:  r = {63'd0, a != b};
      sme_pkg::OP_GT:  r = {63'd0, a > b};
      sme_pkg::OP_GE:  r = {63'd0, a >= b};
      sme_pkg::OP_LT:  r = {63'd0, a < b};
      default:         r = {63'd0, a <= b};
    endcase
  end

  always_comb begin
    fault    = 1'b0;
    fcode    = sme_pkg::ST_RUN;
    st_out   = sme_pkg::ST_RUN;
    npc      = pc_r;
    kind     = sme_pkg::K_PLAIN;
    arith_ok = 1'b0;
    ds_we    = 1'b0;
    ds_wa    = dp_r[DI_W-1:0];
    ds_wd    = arg_r;
    cs_we    = 1'b0;
    cs_wa    = cp_r[CI_W-1:0];
    cs_wd    = top_r;
    dp_nxt   = dp_r;
    cp_nxt   = cp_r;
    fp_nxt   = fp_r;
    fd_nxt   = fd_r;
    top_nxt  = top_r;
    stop_nxt = stop_r;
    if (typ_r == sme_pkg::REQ_START) begin
      dp_nxt   = '0;
      cp_nxt   = '0;
      fp_nxt   = '0;
      fd_nxt   = '0;
      stop_nxt = sme_pkg::ST_RUN;
    end else if (stop_r != sme_pkg::ST_RUN) begin
      st_out = stop_r;
    end else begin
      case (op_r)
        sme_pkg::OP_PUSH: begin
          if (32'(dp_r) >= DD) begin
            fault = 1'b1; fcode = sme_pkg::ST_OVER;
          end else begin
            ds_we = 1'b1; dp_nxt = dp_r + DP_W'(1); top_nxt = arg_r; npc = pc9;
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
        sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_GT, sme_pkg::OP_GE,
        sme_pkg::OP_LT, sme_pkg::OP_LE: begin
          if (32'(dp_r) < 32'd2) begin
            fault = 1'b1; fcode = sme_pkg::ST_UNDER;
          end else if (op_r == sme_pkg::OP_DIV && b == 64'd0) begin
            fault = 1'b1; fcode = sme_pkg::ST_DIVZERO;
          end else if (op_r == sme_pkg::OP_MUL || op_r == sme_pkg::OP_DIV) begin
            kind = sme_pkg::K_ARITH; arith_ok = 1'b1;
          end else begin
            ds_we = 1'b1; ds_wa = dp_m2[DI_W-1:0]; ds_wd = r;
            dp_nxt = dp_m1; top_nxt = r; npc = pc1;
          end
        end
        sme_pkg::OP_JMP: begin
          if (tgt_bad) begin
            fault = 1'b1; fcode = sme_pkg::ST_TARGET;
          end else begin
            npc = arg_r[31:0];
          end
        end
        sme_pkg::OP_JEZ: begin
          if (dp_r == '0) begin
            fault = 1'b1; fcode = sme_pkg::ST_UNDER;
          end else if (tgt_bad) begin
            fault = 1'b1; fcode = sme_pkg::ST_TARGET;
          end else begin
            dp_nxt = dp_m1; top_nxt = a;
            npc = (b == 64'd0) ? arg_r[31:0] : pc9;
          end
        end
        sme_pkg::OP_CALL: begin
          if (tgt_bad) begin
            fault = 1'b1; fcode = sme_pkg::ST_TARGET;
          end else if (32'(cp_r) + 32'd2 > CD) begin
            fault = 1'b1; fcode = sme_pkg::ST_RANGE;
          end else begin
            kind = sme_pkg::K_CALL;
            cs_we = 1'b1; cs_wd = 64'(fp_r); npc = arg_r[31:0];
          end
        end
        sme_pkg::OP_RET: begin
          if (fd_r == '0) begin
            fault = 1'b1; fcode = sme_pkg::ST_NOFRAME;
          end else if (32'(fp_r) + 32'd1 >= CD) begin
            fault = 1'b1; fcode = sme_pkg::ST_RANGE;
          end else if (|(cs_rd_b_r & TMASK)) begin
            fault = 1'b1; fcode = sme_pkg::ST_TARGET;
          end else if (cs_rd_a_r > 64'(fp_r)) begin
            fault = 1'b1; fcode = sme_pkg::ST_RANGE;
          end else begin
            cp_nxt = fp_r; fp_nxt = cs_rd_a_r[CP_W-1:0];
            fd_nxt = fd_r - CP_W'(1); npc = cs_rd_b_r[31:0];
          end
        end
        sme_pkg::OP_PSHV: begin
          if (dp_r == '0) begin
            fault = 1'b1; fcode = sme_pkg::ST_UNDER;
          end else if (32'(cp_r) >= CD) begin
            fault = 1'b1; fcode = sme_pkg::ST_RANGE;
          end else begin
            cs_we = 1'b1; cp_nxt = cp_r + CP_W'(1);
            dp_nxt = dp_m1; top_nxt = a; npc = pc1;
          end
        end
        sme_pkg::OP_LDV: begin
          if (loc_bad) begin
            fault = 1'b1; fcode = sme_pkg::ST_RANGE;
          end else if (32'(dp_r) >= DD) begin
            fault = 1'b1; fcode = sme_pkg::ST_OVER;
          end else begin
            ds_we = 1'b1; ds_wd = cs_rd_a_r; dp_nxt = dp_r + DP_W'(1);
            top_nxt = cs_rd_a_r; npc = pc9;
          end
        end
        sme_pkg::OP_STV: begin
          if (dp_r == '0) begin
            fault = 1'b1; fcode = sme_pkg::ST_UNDER;
          end else if (loc_bad) begin
            fault = 1'b1; fcode = sme_pkg::ST_RANGE;
          end else begin
            cs_we = 1'b1; cs_wa = loc_a[CI_W-1:0];
            dp_nxt = dp_m1; top_nxt = a; npc = pc9;
          end
        end
        sme_pkg::OP_HALT: begin
          fault = 1'b1; fcode = sme_pkg::ST_HALT;
        end
        default: begin
          fault = 1'b1; fcode = sme_pkg::ST_UNKNOWN;
        end
      endcase
      if (fault) begin
        stop_nxt = fcode;
        st_out   = fcode;
        npc      = pc_r;
      end
    end
  end

  sme_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.exec && arith_ok),
    .is_div (op_r == sme_pkg::OP_DIV),
    .a      (a),
    .b      (b),
    .done   (md_done),
    .res    (md_res)
  );

  function automatic logic [CI_W-1:0] ra_b_cp();
    logic [CP_W-1:0] t;
    t = cp_r + CP_W'(1);
    return t[CI_W-1:0];
  endfunction

  always_comb begin
    ds_we_x = (cmd.exec && ds_we) || cmd.arith_wb;
    ds_wa_x = cmd.arith_wb ? dp_m2[DI_W-1:0] : ds_wa;
    ds_wd_x = cmd.arith_wb ? md_res : ds_wd;
    cs_we_x = (cmd.exec && cs_we) || cmd.call2 || cmd.clr;
    if (cmd.clr) begin
      cs_wa_x = clr_r;
      cs_wd_x = 64'd0;
    end else if (cmd.call2) begin
      cs_wa_x = ra_b_cp();
      cs_wd_x = {32'd0, pc9};
    end else begin
      cs_wa_x = cs_wa;
      cs_wd_x = cs_wd;
    end
    load_out = (cmd.exec && kind != sme_pkg::K_ARITH) || cmd.arith_wb;
  end

  always_ff @(posedge clk) begin
    if (ds_we_x) ds_mem[ds_wa_x] <= ds_wd_x;
    if (cmd.accept) ds_rd_r <= ds_mem[dp_m2[DI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cs_we_x) cs_mem[cs_wa_x] <= cs_wd_x;
    if (cmd.accept) begin
      cs_rd_a_r <= cs_mem[ra_a[CI_W-1:0]];
      cs_rd_b_r <= cs_mem[ra_b[CI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      typ_r <= in_req_type;
      op_r  <= in_opcode;
      arg_r <= in_argument;
      pc_r  <= {16'd0, in_instr_addr} & AMASK;
    end
    if (cmd.exec) top_r <= top_nxt;
    else if (cmd.arith_wb) top_r <= md_res;
    if (load_out) begin
      o_st_r <= cmd.arith_wb ? sme_pkg::ST_RUN : st_out;
      o_pc_r <= cmd.arith_wb ? pc1[15:0] : npc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r        <= '0;
      cp_r        <= '0;
      fp_r        <= '0;
      fd_r        <= '0;
      stop_r      <= sme_pkg::ST_RUN;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + CI_W'(1);
      if (cmd.exec) begin
        dp_r   <= dp_nxt;
        cp_r   <= cp_nxt;
        fp_r   <= fp_nxt;
        fd_r   <= fd_nxt;
        stop_r <= stop_nxt;
      end else if (cmd.arith_wb) begin
        dp_r <= dp_m1;
      end else if (cmd.call2) begin
        fp_r <= cp_r;
        cp_r <= cp_r + CP_W'(2);
        fd_r <= fd_r + CP_W'(1);
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign dp32 = 32'(dp_r);

  assign st.kind       = kind;
  assign st.arith_done = md_done;
  assign st.clr_last   = (clr_r == CLR_END);
  assign st.out_valid  = out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_status      = o_st_r;
  assign out_next_pc     = o_pc_r;
  assign out_top_value   = (dp_r != '0) ? top_r : 64'd0;
  assign out_stack_count = dp32[8:0];

endmodule

### sv/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// beat and stack/call store reads are registered; S_EXEC loads the result
//   register (mul/div: S_ARITH loads it when the iterative unit is done; call:
//   S_CALL2 writes the call store again); next beat only in S_IDLE, output free
// reset: pointers and status cleared, then a pass zeroes the call store entry by
//   entry while no instruction beat is taken
// ----------------------------------------------------------------------------
module stack_machine_execute_unit #(
  parameter int DATA_DEPTH = 256,
  parameter int CALL_DEPTH = 256,
  parameter int ADDR_BITS  = 16
) (
  input logic      clk,
  input logic      rst_n,
  sme_in_if.sink   in_ch,
  sme_out_if.source out_ch
);

  sme_pkg::cmd_t  cmd;
  sme_pkg::stat_t st;

  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  sme_dpath #(
    .DATA_DEPTH (DATA_DEPTH),
    .CALL_DEPTH (CALL_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (in_ch.req_type),
    .in_opcode       (in_ch.opcode),
    .in_argument     (in_ch.argument),
    .in_instr_addr   (in_ch.instr_addr),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_next_pc     (out_ch.next_pc),
    .out_top_value   (out_ch.top_value),
    .out_stack_count (out_ch.stack_count)
  );

endmodule
